// File: sv/laop_pkg.sv
package laop_pkg;

    localparam int SIZE_W  = 32;
    localparam int LAYER_W = 10;
    localparam int OFF_W   = 40;
    localparam int HI_W    = OFF_W + 1;
    localparam int CAND_W  = 42;
    localparam int ALIGN_W = 5;
    localparam int VIDX_W  = 6;
    localparam int ATTR_W  = SIZE_W + 2 * LAYER_W;

    // Reset alignment is 4096 bytes.
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 5'd12;
    localparam logic [OFF_W-1:0]   MAX40       = {OFF_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_FIND,
        ST_STEP,
        ST_PLACE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic              fits;
        logic [CAND_W-1:0] cand_next;
    } step_res_t;

endpackage

// File: sv/lifetime_arena_offset_planner_core.sv
// Lifetime arena offset planner.
//
// Input channel (in_valid/in_ready): one beat per buffer carrying its size
// and live interval of layers. in_ready is high only while the block is idle,
// where load beats are taken one per cycle.
// A beat with load_last high closes the set and starts planning.
// Planning places buffers largest first using one shared round-up/compare
// unit under a small sequencer. Each placement runs one selection scan,
// then per overlapping block visited one scan plus one step, one more scan
// when no block stops the search, then one place step. Scans read the
// buffer memories through a single read port, one entry at a time.
// Output channel (out_valid/out_ready): one beat per loaded buffer in load
// order; a stalled receiver simply holds the current beat and the sequencer
// waits. After the final beat the set is cleared and in_ready returns.
// Configuration (cfg_valid/cfg_ready): align_log2 is written whenever
// cfg_valid is high; write it only while idle.
// Reset: asynchronous, clears the set, the plan and sets the alignment to
// 4096 bytes. The buffer memories need no clearing pass.
module lifetime_arena_offset_planner_core #(
    parameter int MAX_VALUES = 64,
    parameter int MAX_LAYERS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [laop_pkg::ALIGN_W-1:0]   align_log2,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [laop_pkg::SIZE_W-1:0]    value_size,
    input  logic [laop_pkg::LAYER_W-1:0]   first_layer,
    input  logic [laop_pkg::LAYER_W-1:0]   last_layer,
    input  logic                           load_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [laop_pkg::VIDX_W-1:0]    value_index,
    output logic [laop_pkg::OFF_W-1:0]     offset,
    output logic [laop_pkg::OFF_W-1:0]     arena_total,
    output logic                           overflow,
    output logic                           out_last
);
    import laop_pkg::*;

    localparam int IW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);

    // Buffer memories: attributes written at load, offsets written at place.
    logic [ATTR_W-1:0] attr_mem [MAX_VALUES];
    logic [OFF_W-1:0]  off_mem  [MAX_VALUES];
    logic [ATTR_W-1:0] attr_rd_reg;
    logic [OFF_W-1:0]  off_rd_reg;
    logic [IW-1:0]     rd_addr;

    state_t state_reg, state_next;

    logic [ALIGN_W-1:0]    align_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         done_reg, done_next;
    logic [MAX_VALUES-1:0] placed_reg, placed_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pend_idx_reg, pend_idx_next;

    // Selection tracking
    logic                  best_valid_reg, best_valid_next;
    logic [SIZE_W-1:0]     best_size_reg, best_size_next;
    logic [LAYER_W-1:0]    best_start_reg, best_start_next;
    logic [LAYER_W-1:0]    best_end_reg, best_end_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;

    // Buffer being placed
    logic [SIZE_W-1:0]     at_size_reg, at_size_next;
    logic [LAYER_W-1:0]    at_start_reg, at_start_next;
    logic [LAYER_W-1:0]    at_end_reg, at_end_next;
    logic [IW-1:0]         at_idx_reg, at_idx_next;
    logic [CAND_W-1:0]     cand_reg, cand_next;

    // Next block in (lo, hi) order
    logic                  first_reg, first_next;
    logic                  found_reg, found_next;
    logic [OFF_W-1:0]      min_lo_reg, min_lo_next;
    logic [HI_W-1:0]       min_hi_reg, min_hi_next;
    logic [OFF_W-1:0]      last_lo_reg, last_lo_next;
    logic [HI_W-1:0]       last_hi_reg, last_hi_next;

    logic [OFF_W-1:0]      total_reg, total_next;
    logic                  ovf_reg, ovf_next;

    // Output beat
    logic [IW-1:0]         out_idx_reg, out_idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VIDX_W-1:0]     vidx_reg, vidx_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_acc, out_acc, scan_done, enter;
    logic [SIZE_W-1:0]     e_size;
    logic [LAYER_W-1:0]    e_start, e_end;
    logic [HI_W-1:0]       e_hi;
    logic                  e_cand_ok, e_overlap, e_after;
    logic [LAYER_W-1:0]    first_cl, last_cl;
    logic [HI_W-1:0]       place_end;
    logic [OFF_W-1:0]      place_off, place_end_sat;
    step_res_t             step_res;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid_reg && out_ready;
    assign out_valid   = out_valid_reg;
    assign value_index = vidx_reg;
    assign offset      = offset_reg;
    assign arena_total = total_reg;
    assign overflow    = ovf_reg;
    assign out_last    = out_last_reg;

    // Clamp layer indices above the layer range
    assign first_cl = (32'(first_layer) >= 32'(MAX_LAYERS)) ?
                      LAYER_W'(MAX_LAYERS - 1) : first_layer;
    assign last_cl  = (32'(last_layer) >= 32'(MAX_LAYERS)) ?
                      LAYER_W'(MAX_LAYERS - 1) : last_layer;

    assign {e_size, e_start, e_end} = attr_rd_reg;
    assign e_hi      = HI_W'(off_rd_reg) + HI_W'(e_size);
    assign e_overlap = (at_start_reg <= e_end) && (e_start <= at_end_reg);
    assign e_after   = first_reg || (off_rd_reg > last_lo_reg) ||
                       ((off_rd_reg == last_lo_reg) && (e_hi > last_hi_reg));
    assign e_cand_ok = placed_reg[pend_idx_reg] && e_overlap && e_after;
    assign scan_done = (scan_reg == count_reg) && !pend_reg;
    assign enter     = (state_next != state_reg);

    assign place_off     = (cand_reg > CAND_W'(MAX40)) ? MAX40 : cand_reg[OFF_W-1:0];
    assign place_end     = HI_W'(place_off) + HI_W'(at_size_reg);
    assign place_end_sat = (place_end > HI_W'(MAX40)) ? MAX40 : place_end[OFF_W-1:0];

    laop_step_unit u_step (
        .cand   (cand_reg),
        .size   (at_size_reg),
        .blk_lo (min_lo_reg),
        .blk_hi (min_hi_reg),
        .align  (align_reg),
        .res    (step_res)
    );

    always_comb
    begin
        rd_addr = scan_reg[IW-1:0];
        if (state_reg == ST_OUT_RD)
        begin
            rd_addr = out_idx_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && load_last)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (scan_done)
                begin
                    state_next = found_reg ? ST_STEP : ST_PLACE;
                end
            end
            ST_STEP:
            begin
                state_next = step_res.fits ? ST_PLACE : ST_FIND;
            end
            ST_PLACE:
            begin
                state_next = (done_reg + CW'(1) == count_reg) ? ST_OUT_RD : ST_SEL;
            end
            ST_OUT_RD:   state_next = ST_OUT_LD;
            ST_OUT_LD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (out_acc)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        done_next       = done_reg;
        placed_next     = placed_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_valid_next = best_valid_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        best_idx_next   = best_idx_reg;
        at_size_next    = at_size_reg;
        at_start_next   = at_start_reg;
        at_end_next     = at_end_reg;
        at_idx_next     = at_idx_reg;
        cand_next       = cand_reg;
        first_next      = first_reg;
        found_next      = found_reg;
        min_lo_next     = min_lo_reg;
        min_hi_next     = min_hi_reg;
        last_lo_next    = last_lo_reg;
        last_hi_next    = last_hi_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        out_idx_next    = out_idx_reg;
        out_valid_next  = out_valid_reg;
        vidx_next       = vidx_reg;
        offset_next     = offset_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (count_reg < CW'(MAX_VALUES)))
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_SEL, ST_FIND:
            begin
                // Issue one read per cycle, evaluate it the cycle after
                if (scan_reg < count_reg)
                begin
                    scan_next     = scan_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IW-1:0];
                end
                if (pend_reg && (state_reg == ST_SEL) && !placed_reg[pend_idx_reg])
                begin
                    if (!best_valid_reg || (e_size > best_size_reg) ||
                        ((e_size == best_size_reg) && (e_start < best_start_reg)))
                    begin
                        best_valid_next = 1'b1;
                        best_size_next  = e_size;
                        best_start_next = e_start;
                        best_end_next   = e_end;
                        best_idx_next   = pend_idx_reg;
                    end
                end
                if (pend_reg && (state_reg == ST_FIND) && e_cand_ok)
                begin
                    if (!found_reg || (off_rd_reg < min_lo_reg) ||
                        ((off_rd_reg == min_lo_reg) && (e_hi < min_hi_reg)))
                    begin
                        found_next  = 1'b1;
                        min_lo_next = off_rd_reg;
                        min_hi_next = e_hi;
                    end
                end
                if ((state_reg == ST_SEL) && scan_done)
                begin
                    at_size_next  = best_size_reg;
                    at_start_next = best_start_reg;
                    at_end_next   = best_end_reg;
                    at_idx_next   = best_idx_reg;
                    cand_next     = '0;
                    first_next    = 1'b1;
                end
            end
            ST_STEP:
            begin
                if (!step_res.fits)
                begin
                    cand_next    = step_res.cand_next;
                    last_lo_next = min_lo_reg;
                    last_hi_next = min_hi_reg;
                    first_next   = 1'b0;
                end
            end
            ST_PLACE:
            begin
                placed_next[at_idx_reg] = 1'b1;
                done_next               = done_reg + CW'(1);
                if ((cand_reg > CAND_W'(MAX40)) || (place_end > HI_W'(MAX40)))
                begin
                    ovf_next = 1'b1;
                end
                if (place_end_sat > total_reg)
                begin
                    total_next = place_end_sat;
                end
                out_idx_next = '0;
            end
            ST_OUT_LD:
            begin
                out_valid_next = 1'b1;
                vidx_next      = VIDX_W'(32'(out_idx_reg));
                offset_next    = off_rd_reg;
                out_last_next  = (CW'(out_idx_reg) + CW'(1) == count_reg);
            end
            ST_OUT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    out_idx_next   = out_idx_reg + IW'(1);
                    if (out_last_reg)
                    begin
                        // Drop the set and start fresh
                        count_next  = '0;
                        done_next   = '0;
                        placed_next = '0;
                        total_next  = '0;
                        ovf_next    = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Restart the scan on entry to a scanning state
        if (enter && ((state_next == ST_SEL) || (state_next == ST_FIND)))
        begin
            scan_next       = '0;
            pend_next       = 1'b0;
            best_valid_next = 1'b0;
            found_next      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (count_reg < CW'(MAX_VALUES)))
        begin
            attr_mem[count_reg[IW-1:0]] <= {value_size, first_cl, last_cl};
        end
        if (state_reg == ST_PLACE)
        begin
            off_mem[at_idx_reg] <= place_off;
        end
        attr_rd_reg <= attr_mem[rd_addr];
        off_rd_reg  <= off_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            align_reg      <= ALIGN_RESET;
            count_reg      <= '0;
            done_reg       <= '0;
            placed_reg     <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            first_reg      <= 1'b1;
            found_reg      <= 1'b0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid)
            begin
                align_reg <= align_log2;
            end
            count_reg      <= count_next;
            done_reg       <= done_next;
            placed_reg     <= placed_next;
            scan_reg       <= scan_next;
            pend_reg       <= pend_next;
            best_valid_reg <= best_valid_next;
            first_reg      <= first_next;
            found_reg      <= found_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            out_idx_reg    <= out_idx_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        best_size_reg  <= best_size_next;
        best_start_reg <= best_start_next;
        best_end_reg   <= best_end_next;
        best_idx_reg   <= best_idx_next;
        at_size_reg    <= at_size_next;
        at_start_reg   <= at_start_next;
        at_end_reg     <= at_end_next;
        at_idx_reg     <= at_idx_next;
        cand_reg       <= cand_next;
        min_lo_reg     <= min_lo_next;
        min_hi_reg     <= min_hi_next;
        last_lo_reg    <= last_lo_next;
        last_hi_reg    <= last_hi_next;
        vidx_reg       <= vidx_next;
        offset_reg     <= offset_next;
    end

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while a result beat is pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VALUES))
        else $error("load count beyond capacity");

    a_place_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE) |=> (placed_reg[$past(at_idx_reg)] ||
                                     (state_reg == ST_IDLE)))
        else $error("placed buffer not marked");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_last_reg) |=> ((count_reg == '0) && (placed_reg == '0)))
        else $error("set not cleared after final beat");

endmodule

// File: sv/laop_step_unit.sv
module laop_step_unit (
    input  logic [laop_pkg::CAND_W-1:0]  cand,
    input  logic [laop_pkg::SIZE_W-1:0]  size,
    input  logic [laop_pkg::OFF_W-1:0]   blk_lo,
    input  logic [laop_pkg::HI_W-1:0]    blk_hi,
    input  logic [laop_pkg::ALIGN_W-1:0] align,
    output laop_pkg::step_res_t          res
);
    import laop_pkg::*;

    logic [CAND_W-1:0]   mask;
    logic [CAND_W-1:0]   up;
    logic [CAND_W:0]     need;

    // Round the block end up to the alignment; keep the larger candidate.
    always_comb
    begin
        mask          = (CAND_W'(1) << align) - CAND_W'(1);
        up            = (CAND_W'(blk_hi) + mask) & ~mask;
        need          = (CAND_W+1)'(cand) + (CAND_W+1)'(size);
        res.fits      = (need <= (CAND_W+1)'(blk_lo));
        res.cand_next = (up > cand) ? up : cand;
    end

endmodule
